// File: rtl/cubic_bezier_path_flattener_core_defines.svh
// Assertion macros used by the flattener core RTL
`ifndef CUBIC_BEZIER_PATH_FLATTENER_CORE_DEFINES_SVH
`define CUBIC_BEZIER_PATH_FLATTENER_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define CBPF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cbpf assertion failed");

// Next-cycle implication, disabled in reset
`define CBPF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cbpf assertion failed");

`endif

// File: rtl/cbpf_pkg.sv
package cbpf_pkg;

    localparam int COORD_W = 24;
    localparam int SEG_MAX = 64;
    localparam int SEG_W   = $clog2(SEG_MAX + 1);
    localparam int CUBE_W  = $clog2(SEG_MAX * SEG_MAX * SEG_MAX + 1);
    localparam int SQ3_W   = $clog2(3 * SEG_MAX * SEG_MAX + 1);
    localparam int QUOT_W  = COORD_W;
    localparam int DIV_W   = CUBE_W + QUOT_W;
    localparam int ACC_W   = DIV_W + 1;
    localparam int CNT_W   = $clog2(QUOT_W);

    localparam logic [1:0] OP_MOVE  = 2'd0;
    localparam logic [1:0] OP_LINE  = 2'd1;
    localparam logic [1:0] OP_CUBIC = 2'd2;
    localparam logic [1:0] OP_END   = 2'd3;

    typedef struct packed {
        logic [1:0]                opcode;
        logic signed [COORD_W-1:0] c1_x;
        logic signed [COORD_W-1:0] c1_y;
        logic signed [COORD_W-1:0] c2_x;
        logic signed [COORD_W-1:0] c2_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      last_of_run;
        logic                      is_closing;
    } t_out;

    typedef struct packed {
        logic mul_en;
        logic acc_load;
        logic acc_add;
    } t_mac_ctl;

    typedef struct packed {
        logic start;
        logic step;
    } t_div_ctl;

    typedef logic [SEG_MAX:0][CUBE_W-1:0] t_cube_tbl;
    typedef logic [SEG_MAX:0][SQ3_W-1:0]  t_sq3_tbl;

    function automatic t_cube_tbl f_cube_tbl();
        t_cube_tbl t;
        for (int i = 0; i <= SEG_MAX; i++) begin
            t[i] = CUBE_W'(i * i * i);
        end
        return t;
    endfunction

    function automatic t_sq3_tbl f_sq3_tbl();
        t_sq3_tbl t;
        for (int i = 0; i <= SEG_MAX; i++) begin
            t[i] = SQ3_W'(3 * i * i);
        end
        return t;
    endfunction

    localparam t_cube_tbl CUBE_TBL = f_cube_tbl();
    localparam t_sq3_tbl  SQ3_TBL  = f_sq3_tbl();

endpackage

// File: rtl/cbpf_mac.sv
module cbpf_mac (
    input  logic                                   i_clk,
    input  cbpf_pkg::t_mac_ctl                     i_ctl,
    input  logic [cbpf_pkg::CUBE_W-1:0]            i_coef,
    input  logic signed [cbpf_pkg::COORD_W-1:0]    i_opnd,
    output logic signed [cbpf_pkg::ACC_W-1:0]      o_prod,
    output logic signed [cbpf_pkg::ACC_W-1:0]      o_acc
);
    import cbpf_pkg::*;

    logic signed [ACC_W-1:0] prod_c;
    logic signed [ACC_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;

    assign prod_c = ACC_W'($signed({1'b0, i_coef}) * i_opnd);

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= prod_c;
        end
        if (i_ctl.acc_load) begin
            r_acc <= r_prod;
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

// File: rtl/cbpf_div.sv
module cbpf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cbpf_pkg::t_div_ctl            i_ctl,
    input  logic [cbpf_pkg::DIV_W-1:0]    i_num,
    input  logic [cbpf_pkg::CUBE_W-1:0]   i_den,
    output logic [cbpf_pkg::QUOT_W-1:0]   o_quot,
    output logic                          o_last
);
    import cbpf_pkg::*;

    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dsh;
    logic [QUOT_W-1:0] r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic              ge;

    assign ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.start) begin
            r_cnt <= CNT_W'(QUOT_W - 1);
        end else if (i_ctl.step) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= i_num;
            r_dsh <= DIV_W'({i_den, {(QUOT_W-1){1'b0}}});
            r_quo <= '0;
        end else if (i_ctl.step) begin
            r_rem <= ge ? (r_rem - r_dsh) : r_rem;
            r_dsh <= r_dsh >> 1;
            r_quo <= {r_quo[QUOT_W-2:0], ge};
        end
    end

    assign o_quot = {r_quo[QUOT_W-2:0], ge};
    assign o_last = (r_cnt == '0);

endmodule

// File: rtl/cubic_bezier_path_flattener_core.sv
// Move, line and path-opening elements: result valid in the cycle after transfer.
// End element: one result when the path closes, none otherwise.
// Cubic element: per point, coefficient steps, then for x and y in turn multiply-accumulate,
// divider load and divide steps; the next point starts only once the previous one has transferred.
// Next input is taken once the last result of the item has transferred.
// Synchronous active-low reset clears the path state and sets segment_count to 1.
`include "cubic_bezier_path_flattener_core_defines.svh"

module cubic_bezier_path_flattener_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cbpf_pkg::SEG_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  cbpf_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output cbpf_pkg::t_out                o_out_data
);
    import cbpf_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_COEF  = 6'b000010,
        ST_MAC   = 6'b000100,
        ST_DIVLD = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    t_state                    r_state, n_state;
    logic [2:0]                r_step, n_step;
    logic                      r_axis, n_axis;
    logic [SEG_W-1:0]          r_j, n_j;
    logic [SEG_W-1:0]          r_seg_n;
    logic                      r_path_open, n_path_open;
    logic                      r_closed, n_closed;
    logic                      r_out_valid, n_out_valid;
    logic signed [COORD_W-1:0] r_start_x, r_start_y;
    logic signed [COORD_W-1:0] r_prev_x, r_prev_y;

    t_in                       r_item;
    logic signed [COORD_W-1:0] r_p0_x, r_p0_y;
    logic [CUBE_W-1:0]         r_coef_b, r_coef_c;
    logic [QUOT_W-1:0]         r_qx;
    t_out                      r_out;

    logic                      in_xfer, out_xfer;
    logic [SEG_W-1:0]          k;
    logic [CUBE_W-1:0]         coef;
    logic signed [COORD_W-1:0] opnd;
    t_mac_ctl                  mac_ctl;
    t_div_ctl                  div_ctl;
    logic signed [ACC_W-1:0]   prod;
    logic signed [ACC_W-1:0]   acc;
    logic [CUBE_W-1:0]         den;
    logic [ACC_W-1:0]          bias;
    logic [ACC_W-1:0]          num_full;
    logic [QUOT_W-1:0]         quot;
    logic                      div_last;
    logic                      div_done;
    logic signed [COORD_W-1:0] pt_x, pt_y;
    logic                      start_eq_prev;
    t_out                      in_out;

    assign in_xfer  = i_in_valid & o_in_ready;
    assign out_xfer = r_out_valid & i_out_ready;
    assign k        = r_seg_n - r_j;
    assign div_done = (r_state == ST_DIV) & div_last;
    assign start_eq_prev = (r_start_x == r_prev_x) && (r_start_y == r_prev_y);

    always_comb begin
        coef = CUBE_TBL[r_j];
        opnd = r_axis ? r_item.end_y : r_item.end_x;
        if (r_state == ST_COEF) begin
            if (r_step == 3'd0) begin
                coef = CUBE_W'(SQ3_TBL[k]);
                opnd = $signed(COORD_W'(r_j));
            end else begin
                coef = CUBE_W'(SQ3_TBL[r_j]);
                opnd = $signed(COORD_W'(k));
            end
        end else begin
            case (r_step)
                3'd0: begin
                    coef = CUBE_TBL[k];
                    opnd = r_axis ? r_p0_y : r_p0_x;
                end
                3'd1: begin
                    coef = r_coef_b;
                    opnd = r_axis ? r_item.c1_y : r_item.c1_x;
                end
                3'd2: begin
                    coef = r_coef_c;
                    opnd = r_axis ? r_item.c2_y : r_item.c2_x;
                end
                default: begin
                    coef = CUBE_TBL[r_j];
                    opnd = r_axis ? r_item.end_y : r_item.end_x;
                end
            endcase
        end
    end

    assign mac_ctl.mul_en   = (r_state == ST_COEF) | ((r_state == ST_MAC) & (r_step < 3'd4));
    assign mac_ctl.acc_load = (r_state == ST_MAC) & (r_step == 3'd1);
    assign mac_ctl.acc_add  = (r_state == ST_MAC) & (r_step >= 3'd2);

    cbpf_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_coef (coef),
        .i_opnd (opnd),
        .o_prod (prod),
        .o_acc  (acc)
    );

    // offset by den << (QUOT_W-1) keeps the dividend positive; round half up
    assign den      = CUBE_TBL[r_seg_n];
    assign bias     = ACC_W'({den, {(QUOT_W-1){1'b0}}}) + ACC_W'(den >> 1);
    assign num_full = ACC_W'(acc) + bias;

    assign div_ctl.start = (r_state == ST_DIVLD);
    assign div_ctl.step  = (r_state == ST_DIV);

    cbpf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (num_full[DIV_W-1:0]),
        .i_den   (den),
        .o_quot  (quot),
        .o_last  (div_last)
    );

    assign pt_x = $signed({~r_qx[QUOT_W-1], r_qx[QUOT_W-2:0]});
    assign pt_y = $signed({~quot[QUOT_W-1], quot[QUOT_W-2:0]});

    always_comb begin
        if (i_in_data.opcode == OP_END) begin
            in_out = '{out_x: r_start_x, out_y: r_start_y,
                       last_of_run: 1'b1, is_closing: 1'b1};
        end else begin
            in_out = '{out_x: i_in_data.c1_x, out_y: i_in_data.c1_y,
                       last_of_run: 1'b1, is_closing: 1'b0};
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_axis      = r_axis;
        n_j         = r_j;
        n_path_open = r_path_open;
        n_closed    = r_closed;
        n_out_valid = r_out_valid;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_in_data.opcode == OP_END) begin
                        if (r_path_open) begin
                            n_path_open = 1'b0;
                            n_closed    = r_closed | start_eq_prev;
                            if (r_closed | start_eq_prev) begin
                                n_out_valid = 1'b1;
                                n_state     = ST_OUT;
                            end
                        end
                    end else if (!r_path_open || i_in_data.opcode != OP_CUBIC) begin
                        n_path_open = 1'b1;
                        n_out_valid = 1'b1;
                        n_state     = ST_OUT;
                    end else begin
                        n_j     = SEG_W'(1);
                        n_step  = 3'd0;
                        n_state = ST_COEF;
                    end
                end
            end
            ST_COEF: begin
                if (r_step == 3'd1) begin
                    n_step  = 3'd0;
                    n_axis  = 1'b0;
                    n_state = ST_MAC;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            ST_MAC: begin
                if (r_step == 3'd4) begin
                    n_state = ST_DIVLD;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            ST_DIVLD: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_last) begin
                    if (!r_axis) begin
                        n_axis  = 1'b1;
                        n_step  = 3'd0;
                        n_state = ST_MAC;
                    end else begin
                        n_out_valid = 1'b1;
                        n_state     = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (out_xfer) begin
                    n_out_valid = 1'b0;
                    if (r_out.last_of_run) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_step  = 3'd0;
                        n_state = ST_COEF;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_axis      <= 1'b0;
            r_j         <= SEG_W'(1);
            r_seg_n     <= SEG_W'(1);
            r_path_open <= 1'b0;
            r_closed    <= 1'b0;
            r_out_valid <= 1'b0;
            r_start_x   <= '0;
            r_start_y   <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_axis      <= n_axis;
            r_j         <= n_j;
            r_path_open <= n_path_open;
            r_closed    <= n_closed;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_wdata == '0) begin
                    r_seg_n <= SEG_W'(1);
                end else if (i_cfg_wdata > SEG_W'(SEG_MAX)) begin
                    r_seg_n <= SEG_W'(SEG_MAX);
                end else begin
                    r_seg_n <= i_cfg_wdata;
                end
            end
            if (in_xfer && i_in_data.opcode != OP_END) begin
                if (!r_path_open) begin
                    r_start_x <= i_in_data.c1_x;
                    r_start_y <= i_in_data.c1_y;
                    r_prev_x  <= i_in_data.c1_x;
                    r_prev_y  <= i_in_data.c1_y;
                end else if (i_in_data.opcode != OP_CUBIC) begin
                    r_prev_x <= i_in_data.c1_x;
                    r_prev_y <= i_in_data.c1_y;
                end
            end
            if (div_done && r_axis) begin
                r_prev_x <= pt_x;
                r_prev_y <= pt_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= i_in_data;
            r_p0_x <= r_prev_x;
            r_p0_y <= r_prev_y;
            r_out  <= in_out;
        end
        if (r_state == ST_COEF && r_step == 3'd1) begin
            r_coef_b <= prod[CUBE_W-1:0];
        end
        if (r_state == ST_MAC && r_step == 3'd0 && !r_axis) begin
            r_coef_c <= prod[CUBE_W-1:0];
        end
        if (div_done && !r_axis) begin
            r_qx <= quot;
        end
        if (div_done && r_axis) begin
            r_out <= '{out_x: pt_x, out_y: pt_y,
                       last_of_run: (r_j == r_seg_n), is_closing: 1'b0};
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `CBPF_ASSERT_NOW(a_ready_excl_valid, i_clk, i_rst_n, o_in_ready, !o_out_valid)
    `CBPF_ASSERT_NOW(a_closing_is_last, i_clk, i_rst_n, o_out_valid && o_out_data.is_closing, o_out_data.last_of_run)
    `CBPF_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_out_data.last_of_run, (r_state == ST_COEF) && !o_in_ready)
    `CBPF_ASSERT_NEXT(a_div_to_next, i_clk, i_rst_n, div_done && r_axis, o_out_valid && !o_in_ready)

endmodule
